[rtl/core/ic_pkg.sv]
// ----------------------------------------------------------------------------
// ic_pkg
// Shared sizes, types and state codes of the inversion counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ic_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int VALUE_WIDTH  = 32;
   localparam int SAMPLE_W     = 32;
   localparam int TOTAL_W      = 19;

   localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
   localparam int SPAN_W  = CNT_W + 2;
   localparam int ACC_W   = 2 * CNT_W;
   localparam int SAT_W   = (ACC_W > TOTAL_W) ? ACC_W : TOTAL_W;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one word between front and back
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;   // sign bit flipped, unsigned order
      logic                   store;   // 0: store was full, word dropped
      logic                   last;
   } ic_entry_type;

   typedef struct packed {
      logic         valid;
      ic_entry_type entry;
   } ic_head_type;

   typedef struct packed {
      logic                   en;
      logic [ADDR_W-1:0]      addr;
      logic [VALUE_WIDTH-1:0] data;
   } ic_wr_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_PASS,
      BK_RUN,
      BK_PRIME,
      BK_MERGE,
      BK_DONE
   } ic_back_state_type;

endpackage

`default_nettype wire

[rtl/core/ic_ram.sv]
// ----------------------------------------------------------------------------
// ic_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

[rtl/core/ic_front.sv]
// ----------------------------------------------------------------------------
// ic_front
// Accepts input words, maps values to unsigned order and marks drops.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_front import ic_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [SAMPLE_W-1:0] req_sample_value,
   input  wire logic                req_final_item,
   input  wire logic                q_full,
   output logic                     q_push,
   output ic_entry_type             q_entry
);

   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic signed [VALUE_WIDTH-1:0] ext_value;
   logic                         has_room;

   assign req_full  = q_full;
   assign q_push    = req_push && !q_full;
   assign has_room  = count_ff < CNT_W'(MAX_ELEMENTS);
   // low value bits, sign extended when the value is wider than the port
   assign ext_value = VALUE_WIDTH'($signed(req_sample_value));

   always_comb begin
      q_entry.value = ext_value ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      q_entry.store = has_room;
      q_entry.last  = req_final_item;
      count_in      = count_ff;
      if (q_push) begin
         if (req_final_item) begin
            count_in = '0;
         end else if (has_room) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/ic_queue.sv]
// ----------------------------------------------------------------------------
// ic_queue
// Short word queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_queue import ic_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire ic_entry_type push_entry,
   output logic        full,
   input  wire logic   pop,
   output ic_head_type head
);

   ic_entry_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] fill_ff;
   logic              do_pop;

   assign full       = fill_ff == QCNT_W'(QUEUE_DEPTH);
   assign head.valid = fill_ff != '0;
   assign head.entry = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !do_pop) begin
            fill_ff <= fill_ff + QCNT_W'(1);
         end else if (do_pop && !push) begin
            fill_ff <= fill_ff - QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/ic_back.sv]
// ----------------------------------------------------------------------------
// ic_back
// Loads words into the store, then merge-sorts bottom-up between two RAMs
// and counts inversions; holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_back import ic_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ic_head_type            q_head,
   output logic                        q_pop,
   output ic_wr_type                   wr0,
   output ic_wr_type                   wr1,
   output logic [ADDR_W-1:0]           rd_addr_a,
   output logic [ADDR_W-1:0]           rd_addr_b,
   input  wire logic [VALUE_WIDTH-1:0] rd0_a,
   input  wire logic [VALUE_WIDTH-1:0] rd0_b,
   input  wire logic [VALUE_WIDTH-1:0] rd1_a,
   input  wire logic [VALUE_WIDTH-1:0] rd1_b,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output logic [TOTAL_W-1:0]          rsp_inversion_total,
   output logic                        rsp_overflow_flag
);

   ic_back_state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              drop_ff, drop_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [SPAN_W-1:0] w_ff, w_in;
   logic [SPAN_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0]  mid_ff, mid_in;
   logic [CNT_W-1:0]  hi_ff, hi_in;
   logic [CNT_W-1:0]  a_ff, a_in;
   logic [CNT_W-1:0]  b_ff, b_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              src_ff, src_in;
   logic              out_valid_ff, out_valid_in;
   logic [TOTAL_W-1:0] out_total_ff, out_total_in;
   logic              out_ovf_ff, out_ovf_in;

   logic [SPAN_W-1:0]      n_span;
   logic [SPAN_W-1:0]      lo_w;
   logic [SPAN_W-1:0]      lo_2w;
   logic [VALUE_WIDTH-1:0] head_a;
   logic [VALUE_WIDTH-1:0] head_b;
   logic                   take_b;
   logic [CNT_W-1:0]       a_nx;
   logic [CNT_W-1:0]       b_nx;
   logic [VALUE_WIDTH-1:0] pick;

   assign n_span = SPAN_W'(cnt_ff);
   assign lo_w   = lo_ff + w_ff;
   assign lo_2w  = lo_ff + (w_ff << 1);
   assign head_a = src_ff ? rd1_a : rd0_a;
   assign head_b = src_ff ? rd1_b : rd0_b;

   // stable merge: ties go to the left run
   assign take_b = !(a_ff < mid_ff) || ((b_ff < hi_ff) && (head_a > head_b));
   assign a_nx   = take_b ? a_ff : a_ff + CNT_W'(1);
   assign b_nx   = take_b ? b_ff + CNT_W'(1) : b_ff;
   assign pick   = take_b ? head_b : head_a;

   assign rd_addr_a = (state_ff == BK_MERGE) ? a_nx[ADDR_W-1:0] : a_ff[ADDR_W-1:0];
   assign rd_addr_b = (state_ff == BK_MERGE) ? b_nx[ADDR_W-1:0] : b_ff[ADDR_W-1:0];

   assign rsp_empty           = !out_valid_ff;
   assign rsp_inversion_total = out_total_ff;
   assign rsp_overflow_flag   = out_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      acc_in       = acc_ff;
      w_in         = w_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      src_in       = src_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_total_in = out_total_ff;
      out_ovf_in   = out_ovf_ff;
      q_pop        = 1'b0;
      wr0          = '{en: 1'b0, addr: k_ff[ADDR_W-1:0], data: pick};
      wr1          = '{en: 1'b0, addr: k_ff[ADDR_W-1:0], data: pick};

      case (state_ff)
         BK_LOAD: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.entry.store) begin
                  wr0.en   = 1'b1;
                  wr0.addr = cnt_ff[ADDR_W-1:0];
                  wr0.data = q_head.entry.value;
                  cnt_in   = cnt_ff + CNT_W'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (q_head.entry.last) begin
                  w_in     = SPAN_W'(1);
                  src_in   = 1'b0;
                  acc_in   = '0;
                  state_in = BK_PASS;
               end
            end
         end
         BK_PASS: begin
            lo_in    = '0;
            state_in = (w_ff < n_span) ? BK_RUN : BK_DONE;
         end
         BK_RUN: begin
            if (lo_ff < n_span) begin
               // a lone tail run is copied across as a merge with an empty right run
               mid_in   = (lo_w > n_span) ? cnt_ff : lo_w[CNT_W-1:0];
               hi_in    = (lo_2w > n_span) ? cnt_ff : lo_2w[CNT_W-1:0];
               a_in     = lo_ff[CNT_W-1:0];
               b_in     = (lo_w > n_span) ? cnt_ff : lo_w[CNT_W-1:0];
               k_in     = lo_ff[CNT_W-1:0];
               state_in = BK_PRIME;
            end else begin
               w_in     = w_ff << 1;
               src_in   = !src_ff;
               state_in = BK_PASS;
            end
         end
         BK_PRIME: begin
            state_in = BK_MERGE;
         end
         BK_MERGE: begin
            wr0.en = src_ff;
            wr1.en = !src_ff;
            if (take_b) begin
               acc_in = acc_ff + ACC_W'(mid_ff - a_ff);
            end
            a_in = a_nx;
            b_in = b_nx;
            k_in = k_ff + CNT_W'(1);
            if (k_ff + CNT_W'(1) == hi_ff) begin
               lo_in    = SPAN_W'(hi_ff);
               state_in = BK_RUN;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               out_total_in = (SAT_W'(acc_ff) > SAT_W'(TOTAL_MAX)) ?
                              TOTAL_MAX : TOTAL_W'(acc_ff);
               out_ovf_in   = drop_ff;
               cnt_in       = '0;
               drop_in      = 1'b0;
               state_in     = BK_LOAD;
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_LOAD;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         acc_ff       <= '0;
         src_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         acc_ff       <= acc_in;
         src_ff       <= src_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff         <= w_in;
      lo_ff        <= lo_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      k_ff         <= k_in;
      out_total_ff <= out_total_in;
      out_ovf_ff   <= out_ovf_in;
   end

endmodule

`default_nettype wire

[rtl/core/inversion_counter.sv]
// A word taken passes through the queue into the store; while the back is loading, the store takes
// one word a cycle. After the last word, the back sorts the stored words bottom-up, one merge step
// per cycle, since both merge heads come from the two read ports of the RAM that holds the runs.
// Reset is synchronous and clears control state only; RAM contents are never cleared.
// ----------------------------------------------------------------------------
// inversion_counter
// Stores a sequence of signed values and counts its inversions by merge sort.
// ----------------------------------------------------------------------------
`default_nettype none

module inversion_counter import ic_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [SAMPLE_W-1:0] req_sample_value,
   input  wire logic                req_final_item,
   output logic                     rsp_empty,
   input  wire logic                rsp_pop,
   output logic [TOTAL_W-1:0]       rsp_inversion_total,
   output logic                     rsp_overflow_flag
);

   logic                   q_full;
   logic                   q_push;
   ic_entry_type           q_entry;
   logic                   q_pop;
   ic_head_type            q_head;
   ic_wr_type              wr0;
   ic_wr_type              wr1;
   logic [ADDR_W-1:0]      rd_addr_a;
   logic [ADDR_W-1:0]      rd_addr_b;
   logic [VALUE_WIDTH-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

   ic_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_sample_value (req_sample_value),
      .req_final_item   (req_final_item),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   ic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   ic_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_store (
      .clock     (clock),
      .wr_en     (wr0.en),
      .wr_addr   (wr0.addr),
      .wr_data   (wr0.data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd0_a),
      .rd_data_b (rd0_b)
   );

   ic_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ELEMENTS)) u_scratch (
      .clock     (clock),
      .wr_en     (wr1.en),
      .wr_addr   (wr1.addr),
      .wr_data   (wr1.data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd1_a),
      .rd_data_b (rd1_b)
   );

   ic_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_head              (q_head),
      .q_pop               (q_pop),
      .wr0                 (wr0),
      .wr1                 (wr1),
      .rd_addr_a           (rd_addr_a),
      .rd_addr_b           (rd_addr_b),
      .rd0_a               (rd0_a),
      .rd0_b               (rd0_b),
      .rd1_a               (rd1_a),
      .rd1_b               (rd1_b),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_inversion_total (rsp_inversion_total),
      .rsp_overflow_flag   (rsp_overflow_flag)
   );

endmodule

`default_nettype wire

[rtl/core/ic_checker.sv]
// ----------------------------------------------------------------------------
// ic_checker
// Port-level checks of the inversion counter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ic_checker import ic_pkg::*; (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_push,
   input wire logic                req_full,
   input wire logic                rsp_empty,
   input wire logic                rsp_pop,
   input wire logic [TOTAL_W-1:0]  rsp_inversion_total,
   input wire logic                rsp_overflow_flag
);

   // one result register: a taken result leaves it empty for a cycle
   a_pop_empties: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_pop |=> rsp_empty)
      else $error("result register refilled right after a pop");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or queue not clear after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_inversion_total)
                                 && $stable(rsp_overflow_flag))
      else $error("waiting result changed");

   a_total_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_inversion_total != TOTAL_MAX) ||
                     (MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2 >= TOTAL_MAX))
      else $error("saturated count that cannot occur");

   // with no input ever pushed the queue cannot fill
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      !req_full && !(req_push && !req_full) |=> !req_full)
      else $error("queue filled without a push");

endmodule

bind inversion_counter ic_checker u_checker (.*);

`default_nettype wire

[test/inversion_counter_tb.sv]
// ----------------------------------------------------------------------------
// inversion_counter_tb
// Feeds sequences of signed words to the inversion counter and checks every
// count and overflow flag against a pair-counting predictor in the bench.
// Directed sequences cover the signed extremes, equal values and order.
// Random sequences follow, mostly short, plus one strictly descending set
// that runs past the store. Both sides idle at random, and the receiver
// holds off once long enough to back the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module inversion_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ic_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 2500;
   localparam int HOLD_AFTER   = 4;
   localparam int QUIET_FROM   = 3000;
   localparam int QUIET_TO     = 9000;
   localparam int IDLE_PCT     = 8;
   localparam int DRAIN_CYCLES = 100;
   localparam int SMALL_ITEMS  = 150;

   localparam logic [SAMPLE_W-1:0] VALUE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [SAMPLE_W-1:0] VALUE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                last;
   } sample_word_type;

   typedef struct {
      logic [TOTAL_W-1:0] total;
      logic               overflow;
   } count_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   logic                req_full;
   logic [SAMPLE_W-1:0] req_sample_value = '0;
   logic                req_final_item = 1'b0;
   logic                rsp_empty;
   logic                rsp_pop = 1'b0;
   logic [TOTAL_W-1:0]  rsp_inversion_total;
   logic                rsp_overflow_flag;

   sample_word_type               pending_words[$];
   count_result_type              expected_counts[$];
   logic signed [VALUE_WIDTH-1:0] held_values[$];
   logic                          held_dropped = 1'b0;

   int   error_count  = 0;
   int   results_seen = 0;
   int   cycle_count  = 0;
   logic hold_active  = 1'b0;

   inversion_counter dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_sample_value    (req_sample_value),
      .req_final_item      (req_final_item),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_inversion_total (rsp_inversion_total),
      .rsp_overflow_flag   (rsp_overflow_flag)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // plain pair count over the stored elements, signed compare
   function automatic longint count_inversions();
      longint n = 0;
      for (int i = 0; i < held_values.size(); i++) begin
         for (int j = i + 1; j < held_values.size(); j++) begin
            if (held_values[i] > held_values[j]) n++;
         end
      end
      return n;
   endfunction

   function automatic void absorb_word(input sample_word_type w);
      longint           n;
      count_result_type r;
      if (held_values.size() < MAX_ELEMENTS) held_values.push_back(w.value[VALUE_WIDTH-1:0]);
      else held_dropped = 1'b1;
      if (w.last) begin
         n = count_inversions();
         r.total    = (n > longint'(TOTAL_MAX)) ? TOTAL_MAX : n[TOTAL_W-1:0];
         r.overflow = held_dropped;
         expected_counts.push_back(r);
         held_values.delete();
         held_dropped = 1'b0;
      end
   endfunction

   function automatic bit roll_idle();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_value(input int mode);
      case (mode)
         0: return $urandom;
         // narrow range, lots of equal values
         1: return SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
         2: begin
            case ($urandom_range(0, 3))
               0:       return VALUE_MIN;
               1:       return VALUE_MAX;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return $urandom & 32'h8000_00FF;
      endcase
   endfunction

   task automatic add_word(input logic [SAMPLE_W-1:0] value, input logic last);
      sample_word_type w;
      w.value = value;
      w.last  = last;
      pending_words.push_back(w);
   endtask

   task automatic add_sequence(input int len, input int mode);
      for (int i = 0; i < len; i++) add_word(pick_value(mode), i == len - 1);
   endtask

   // stimulus, reset and end of run
   initial begin
      int     small_items;
      int     len;
      bit     full_done;
      longint d;
      small_items = 0;
      full_done   = 1'b0;

      add_word('0, 1'b1);
      add_word(VALUE_MAX, 1'b0);
      add_word(VALUE_MIN, 1'b1);
      add_word(VALUE_MIN, 1'b0);
      add_word(VALUE_MAX, 1'b1);
      add_word('0, 1'b0);
      add_word('1, 1'b0);
      add_word('1, 1'b0);
      add_word(32'd5, 1'b0);
      add_word(32'd5, 1'b1);
      add_word(32'd3, 1'b0);
      add_word(32'd2, 1'b0);
      add_word(32'd1, 1'b1);
      add_word(VALUE_MAX, 1'b0);
      add_word(VALUE_MAX, 1'b0);
      add_word(VALUE_MAX, 1'b1);
      add_word(32'hAAAA_AAAA, 1'b0);
      add_word(32'h5555_5555, 1'b1);
      add_word(32'h5555_5555, 1'b0);
      add_word(32'hAAAA_AAAA, 1'b1);

      while (small_items < SMALL_ITEMS) begin
         if (!full_done && small_items >= SMALL_ITEMS / 3) begin
            // strictly descending full set, most inversions possible; it runs
            // past the store and the last word is dropped too
            for (int i = 0; i < MAX_ELEMENTS + 6; i++) begin
               d = 64'sh7FFF_FFFF - longint'(i) * (64'sd1 << 22);
               add_word(d[SAMPLE_W-1:0], i == MAX_ELEMENTS + 5);
            end
            full_done = 1'b1;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(1, 12);
         add_sequence(len, $urandom_range(0, 3));
         small_items += len;
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_words.size() != 0 || expected_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // long receiver hold-off once results are flowing, sender keeps pushing
   initial begin
      while (results_seen < HOLD_AFTER) @(posedge clock);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_active = 1'b0;
   end

   always @(negedge clock) begin
      if (reset || pending_words.size() == 0 || roll_idle()) begin
         req_push <= 1'b0;
      end else begin
         req_push         <= 1'b1;
         req_sample_value <= pending_words[0].value;
         req_final_item   <= pending_words[0].last;
      end
   end

   always @(negedge clock) begin
      if (reset || hold_active || roll_idle()) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin : monitor
      sample_word_type  w;
      count_result_type e;
      if (!reset) begin
         if (req_push && !req_full) begin
            w.value = req_sample_value;
            w.last  = req_final_item;
            void'(pending_words.pop_front());
            absorb_word(w);
         end
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("word with none expected: total %0d overflow %0b",
                                         rsp_inversion_total, rsp_overflow_flag));
            end else begin
               e = expected_counts.pop_front();
               if (rsp_inversion_total !== e.total)
                  report_mismatch($sformatf("inversion_total %0d, expected %0d",
                                            rsp_inversion_total, e.total));
               if (rsp_overflow_flag !== e.overflow)
                  report_mismatch($sformatf("overflow_flag %0b, expected %0b",
                                            rsp_overflow_flag, e.overflow));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule

`default_nettype wire

[inversion_counter.f]
rtl/core/ic_pkg.sv
rtl/core/ic_ram.sv
rtl/core/ic_front.sv
rtl/core/ic_queue.sv
rtl/core/ic_back.sv
rtl/core/inversion_counter.sv
rtl/core/ic_checker.sv
test/inversion_counter_tb.sv
